@@ rtl/core/memory_overwrite_lock_control_core_macros.svh @@
// Assertion macros for the memory overwrite lock control core.
`ifndef MEMORY_OVERWRITE_LOCK_CONTROL_CORE_MACROS_SVH
`define MEMORY_OVERWRITE_LOCK_CONTROL_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, quiet while arst_n is low
`define MOLC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low
`define MOLC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define MOLC_ASSERT_NOW(lbl, ante, cons, msg)
`define MOLC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/core/molc_pkg.sv @@
// Shared types and constants of the memory overwrite lock control core.
`default_nettype none

package molc_pkg;

	// Key length in bytes and derived widths
	localparam int KEY_BYTES = 8;
	localparam int KEY_W = 8 * KEY_BYTES;
	localparam logic [7:0] KEY_LEN = 8'(KEY_BYTES);

	// Bits a control byte may carry
	localparam logic [7:0] ACTION_MASK = 8'h11;

	// Attribute word after reset: boot, runtime, nonvolatile
	localparam logic [31:0] ATTR_RESET = 32'd7;

	// Stream widths, padded to whole bytes
	localparam int IN_TDATA_W = 112;
	localparam int OUT_TDATA_W = 16;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_WPROT   = 2'd2,
		ST_DENIED  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		LK_OPEN  = 2'd0,
		LK_NOKEY = 2'd1,
		LK_KEYED = 2'd2
	} lock_t;

	typedef enum logic {
		FN_CONTROL = 1'b0,
		FN_LOCK    = 1'b1
	} func_t;

	typedef struct packed {
		func_t       func;
		logic [31:0] attributes;
		logic        append_flag;
		logic [7:0]  data_length;
		logic [63:0] payload;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  control_value;
		lock_t       lock_value;
	} res_t;

endpackage

`default_nettype wire

@@ rtl/core/molc_in_reg.sv @@
// Input register stage: captures one request word from the slave stream.
`default_nettype none

module molc_in_reg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// s_tdata, low bit up: attributes[31:0], append_flag, data_length[7:0],
	// payload[63:0], zero pad
	input  wire logic [molc_pkg::IN_TDATA_W-1:0]    s_tdata,
	// s_tuser: func
	input  wire logic                               s_tuser,
	input  wire logic                               room,
	output logic                                    valid_s1,
	output molc_pkg::req_t                          req_s1
);
	import molc_pkg::*;

	// Take a new word when the stage is empty or drains this cycle
	assign s_tready = !valid_s1 || room;

	// Hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Unpack the word into its fields
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1.func        <= func_t'(s_tuser);
			req_s1.attributes  <= s_tdata[31:0];
			req_s1.append_flag <= s_tdata[32];
			req_s1.data_length <= s_tdata[40:33];
			req_s1.payload     <= s_tdata[104:41];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/molc_engine.sv @@
// Lock engine: state registers and the single-pass decision logic.
`default_nettype none

module molc_engine (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	input  wire logic [31:0]       cfg_data,
	input  wire logic              fire,
	input  wire molc_pkg::req_t    req,
	output molc_pkg::res_t         res
);
	import molc_pkg::*;

	logic [31:0]      req_attr_q;
	lock_t            lock_q;
	logic [KEY_W-1:0] key_q;
	logic [7:0]       ctrl_q;

	status_t          status_n;
	lock_t            lock_n;
	logic [7:0]       ctrl_n;
	logic             key_we;
	logic [7:0]       b0;
	logic             attr_ok;
	logic             key_match;

	assign b0        = req.payload[7:0];
	assign attr_ok   = (req.attributes == req_attr_q) && !req.append_flag;
	assign key_match = (req.payload[KEY_W-1:0] == key_q);

	// Decide status and next state for the request in the stage
	always_comb begin
		status_n = ST_OK;
		lock_n   = lock_q;
		ctrl_n   = ctrl_q;
		key_we   = 1'b0;
		if (req.func == FN_CONTROL) begin
			if (!attr_ok || req.data_length != 8'd1 || (b0 & ~ACTION_MASK) != 8'd0) begin
				status_n = ST_INVALID;
			end else if (lock_q != LK_OPEN) begin
				status_n = ST_WPROT;
			end else begin
				ctrl_n = b0;
			end
		end else if (req.attributes == 32'd0 || req.data_length == 8'd0) begin
			status_n = ST_WPROT;
		end else if (!attr_ok || (req.data_length != 8'd1 && req.data_length != KEY_LEN)) begin
			status_n = ST_INVALID;
		end else if (req.data_length == 8'd1) begin
			// One-byte write: lock or probe for unlock
			if (b0 == 8'd0) begin
				status_n = (lock_q == LK_OPEN) ? ST_OK : ST_DENIED;
			end else if (b0 == 8'd1) begin
				if (lock_q != LK_OPEN) begin
					status_n = ST_DENIED;
				end else begin
					lock_n = LK_NOKEY;
				end
			end else begin
				status_n = ST_INVALID;
			end
		end else begin
			// Key write: store when open, compare when keyed, deny when keyless
			case (lock_q)
				LK_OPEN: begin
					key_we = 1'b1;
					lock_n = LK_KEYED;
				end
				LK_NOKEY: begin
					status_n = ST_DENIED;
				end
				default: begin
					if (key_match) begin
						lock_n = LK_OPEN;
					end else begin
						lock_n   = LK_NOKEY;
						status_n = ST_DENIED;
					end
				end
			endcase
		end
	end

	assign res.status        = status_n;
	assign res.control_value = ctrl_n;
	assign res.lock_value    = lock_n;

	// Take configuration writes; advance control state when the request leaves the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_attr_q <= ATTR_RESET;
			lock_q     <= LK_OPEN;
			ctrl_q     <= 8'd0;
		end else begin
			if (cfg_valid) begin
				req_attr_q <= cfg_data;
			end
			if (fire) begin
				lock_q <= lock_n;
				ctrl_q <= ctrl_n;
			end
		end
	end

	// Store the key
	always_ff @(posedge clk) begin
		if (fire && key_we) begin
			key_q <= req.payload[KEY_W-1:0];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/molc_out_reg.sv @@
// Result register stage: holds one result word for the master stream.
`default_nettype none

module molc_out_reg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               load,
	input  wire molc_pkg::res_t                     res,
	output logic                                    room,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// m_tdata, low bit up: status[1:0], control_value[7:0], lock_value[1:0],
	// zero pad
	output logic [molc_pkg::OUT_TDATA_W-1:0]        m_tdata
);
	import molc_pkg::*;

	logic          m_tvalid_q;
	res_t          res_q;

	// Room when empty or the held word goes this cycle
	assign room = !m_tvalid_q || m_tready;

	// Hold the valid flag until the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (room) begin
			m_tvalid_q <= load;
		end
	end

	// Capture the result
	always_ff @(posedge clk) begin
		if (load && room) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, res_q.lock_value, res_q.control_value, res_q.status};

endmodule

`default_nettype wire

@@ rtl/core/memory_overwrite_lock_control_core.sv @@
// Top level of the memory overwrite lock control core.
//
//  channel  direction  signals                      contents
//  s        in         s_tvalid/s_tready/s_tdata/   one write request
//                      s_tuser
//  m        out        m_tvalid/m_tready/m_tdata    status, control byte, lock
//  cfg      in         cfg_valid/cfg_ready/cfg_data required attribute word
//
// One request per cycle while m is not stalled; a result word becomes valid
// after its request has passed the input register, then the result register.
// The lock, control byte and key update as a request leaves the input
// register, so the next request sees them with no gap.
// Reset clears the lock to unlocked, the control byte to zero and the
// attribute word to 7; the stored key is undefined until a key is written.
// A stall on m backs up through both registers to s_tready.
`default_nettype none
`include "memory_overwrite_lock_control_core_macros.svh"

module memory_overwrite_lock_control_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// s_tdata, low bit up: attributes[31:0], append_flag, data_length[7:0],
	// payload[63:0], zero pad
	input  wire logic [molc_pkg::IN_TDATA_W-1:0]    s_tdata,
	// s_tuser: func
	input  wire logic                               s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// m_tdata, low bit up: status[1:0], control_value[7:0], lock_value[1:0],
	// zero pad
	output logic [molc_pkg::OUT_TDATA_W-1:0]        m_tdata,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [31:0]                        cfg_data
);
	import molc_pkg::*;

	logic  valid_s1;
	req_t  req_s1;
	res_t  res;
	logic  room;
	logic  fire;

	// Configuration writes are always taken
	assign cfg_ready = 1'b1;

	// Process the staged request when the result register has room
	assign fire = valid_s1 && room;

	molc_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.room     (room),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1)
	);

	molc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.fire      (fire),
		.req       (req_s1),
		.res       (res)
	);

	molc_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (valid_s1),
		.res      (res),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Checks
	`MOLC_ASSERT_NEXT(a_fire_shows_result, fire, m_tvalid, "processed request gave no result")
	`MOLC_ASSERT_NOW(a_stall_cause, !s_tready, valid_s1 && m_tvalid && !m_tready, "input stalled without a downstream stall")
	`MOLC_ASSERT_NEXT(a_drain_empties, m_tvalid && m_tready && !fire, !m_tvalid, "result repeated after it was taken")

endmodule

`default_nettype wire

@@ tb/memory_overwrite_lock_control_core_tb.sv @@
// Self-checking testbench for the memory overwrite lock control core.
`timescale 1ns / 100ps

module memory_overwrite_lock_control_core_tb;
	import molc_pkg::*;

	localparam int CYCLE_LIMIT = 250000;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int SETTLE_CYCLES = 6;

	// Predicted state of the block
	typedef struct {
		lock_t       lock;
		logic [63:0] key;
		logic [7:0]  ctrl;
		logic [31:0] attr_req;
	} guard_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// s_tdata, low bit up: attributes[31:0], append_flag, data_length[7:0],
	// payload[63:0], zero pad
	logic [IN_TDATA_W-1:0] s_tdata;
	// s_tuser: func
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// m_tdata, low bit up: status[1:0], control_value[7:0], lock_value[1:0],
	// zero pad
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [31:0]           cfg_data;

	guard_t guard;
	res_t   pending_results[$];
	int     mismatch_count = 0;
	int     cycle_count = 0;
	bit     idle_on = 1'b1;
	int     hold_cycles = 0;

	memory_overwrite_lock_control_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Clock, 2 ns period
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Apply one request to the predicted state and return the expected word
	function automatic res_t apply_request(inout guard_t g, input req_t r);
		res_t        res;
		status_t     st;
		logic [63:0] km;
		logic [7:0]  b;
		km = {64{1'b1}} >> (64 - KEY_W);
		b = r.payload[7:0];
		if (r.func == FN_CONTROL) begin
			if (r.attributes != g.attr_req || r.append_flag || r.data_length != 8'd1)
				st = ST_INVALID;
			else if ((b & ~ACTION_MASK) != 8'd0)
				st = ST_INVALID;
			else if (g.lock != LK_OPEN)
				st = ST_WPROT;
			else begin
				g.ctrl = b;
				st = ST_OK;
			end
		end else if (r.attributes == 32'd0 || r.data_length == 8'd0) begin
			st = ST_WPROT;
		end else if (r.attributes != g.attr_req || r.append_flag ||
				(r.data_length != 8'd1 && r.data_length != KEY_LEN)) begin
			st = ST_INVALID;
		end else if (r.data_length == 8'd1) begin
			if (b == 8'd0)
				st = (g.lock == LK_OPEN) ? ST_OK : ST_DENIED;
			else if (b == 8'd1) begin
				if (g.lock != LK_OPEN)
					st = ST_DENIED;
				else begin
					g.lock = LK_NOKEY;
					st = ST_OK;
				end
			end else
				st = ST_INVALID;
		end else if (g.lock == LK_OPEN) begin
			g.key = r.payload & km;
			g.lock = LK_KEYED;
			st = ST_OK;
		end else if (g.lock == LK_NOKEY) begin
			st = ST_DENIED;
		end else if ((r.payload & km) != g.key) begin
			g.lock = LK_NOKEY;
			st = ST_DENIED;
		end else begin
			g.lock = LK_OPEN;
			st = ST_OK;
		end
		res.status = st;
		res.control_value = g.ctrl;
		res.lock_value = g.lock;
		return res;
	endfunction

	function automatic req_t make_request(input func_t f, input logic [31:0] a,
			input logic ap, input logic [7:0] n, input logic [63:0] p);
		req_t r;
		r.func = f;
		r.attributes = a;
		r.append_flag = ap;
		r.data_length = n;
		r.payload = p;
		return r;
	endfunction

	// Mostly well-formed writes with random content, some with one field
	// broken, the rest pure noise; unless allowed, steer clear of the
	// keyless lock, which only reset can leave
	function automatic req_t draw_request(input bit may_lock_out);
		req_t   r;
		guard_t probe;
		res_t   res;
		int     pick;
		pick = $urandom_range(0, 99);
		r.func = $urandom_range(0, 1) ? FN_LOCK : FN_CONTROL;
		r.attributes = guard.attr_req;
		r.append_flag = 1'b0;
		r.payload = {$urandom, $urandom};
		if (r.func == FN_CONTROL) begin
			r.data_length = 8'd1;
			if ($urandom_range(0, 3) == 0)
				r.payload[7:0] = 8'($urandom);
			else
				r.payload[7:0] = {3'b000, 1'($urandom_range(0, 1)), 3'b000,
					1'($urandom_range(0, 1))};
		end else if ($urandom_range(0, 1)) begin
			r.data_length = 8'd1;
			case ($urandom_range(0, 3))
				0, 1: r.payload[7:0] = 8'd0;
				2: r.payload[7:0] = 8'd1;
				default: r.payload[7:0] = 8'($urandom);
			endcase
		end else begin
			r.data_length = KEY_LEN;
			if (guard.lock == LK_KEYED && $urandom_range(0, 1))
				r.payload[KEY_W-1:0] = guard.key[KEY_W-1:0];
		end
		if (pick >= 75 && pick < 90) begin
			case ($urandom_range(0, 3))
				0: r.attributes = $urandom;
				1: r.append_flag = 1'b1;
				2: r.data_length = 8'($urandom_range(0, 255));
				default: r.attributes = 32'd0;
			endcase
		end else if (pick >= 90) begin
			r = make_request($urandom_range(0, 1) ? FN_LOCK : FN_CONTROL, $urandom,
				1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
				{$urandom, $urandom});
		end
		if (!may_lock_out) begin
			probe = guard;
			res = apply_request(probe, r);
			if (res.lock_value == LK_NOKEY) begin
				if (guard.lock == LK_OPEN)
					r.payload[7:0] = 8'd0;
				else
					r.payload[KEY_W-1:0] = guard.key[KEY_W-1:0];
			end
		end
		return r;
	endfunction

	// Offer one request; predict its result once the word is taken
	task automatic send_request(input req_t r);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata = '0;
		s_tdata[31:0] = r.attributes;
		s_tdata[32] = r.append_flag;
		s_tdata[40:33] = r.data_length;
		s_tdata[104:41] = r.payload;
		s_tuser = r.func;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(apply_request(guard, r));
		@(negedge clk);
	endtask

	// Hold the sender until every result is back and the pipe is quiet
	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_required_attributes(input logic [31:0] value);
		wait_drained();
		cfg_data = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		guard.attr_req = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic run_random(input int count, input bit may_lock_out);
		repeat (count) send_request(draw_request(may_lock_out));
	endtask

	// Control byte: every legal value, stray bits, and each malformed field
	task automatic test_control_writes();
		logic [31:0] a;
		a = guard.attr_req;
		send_request(make_request(FN_CONTROL, a, 1'b0, 8'd1, 64'h11));
		send_request(make_request(FN_CONTROL, a, 1'b0, 8'd1, 64'h10));
		send_request(make_request(FN_CONTROL, a, 1'b0, 8'd1, 64'hFFFF_FFFF_FFFF_FF01));
		send_request(make_request(FN_CONTROL, a, 1'b0, 8'd1, 64'h0));
		send_request(make_request(FN_CONTROL, a, 1'b0, 8'd1, 64'h02));
		send_request(make_request(FN_CONTROL, a, 1'b0, 8'd1, 64'hFFFF_FFFF_FFFF_FFFF));
		send_request(make_request(FN_CONTROL, a, 1'b1, 8'd1, 64'h11));
		send_request(make_request(FN_CONTROL, a, 1'b0, 8'd0, 64'h11));
		send_request(make_request(FN_CONTROL, a, 1'b0, 8'd255, 64'h01));
		send_request(make_request(FN_CONTROL, 32'hFFFF_FFFF, 1'b0, 8'd1, 64'h01));
	endtask

	// Lock: protection checks, bad lengths and bytes, key store and unlock
	task automatic test_lock_and_key();
		logic [31:0] a;
		logic [63:0] k;
		a = guard.attr_req;
		k = {$urandom, $urandom};
		send_request(make_request(FN_LOCK, 32'd0, 1'b0, 8'd1, 64'h1));
		send_request(make_request(FN_LOCK, a, 1'b0, 8'd0, 64'h1));
		send_request(make_request(FN_LOCK, 32'd0, 1'b1, 8'd0, 64'h0));
		send_request(make_request(FN_LOCK, a, 1'b0, 8'd2, 64'h1));
		send_request(make_request(FN_LOCK, a, 1'b0, 8'd255, k));
		send_request(make_request(FN_LOCK, a, 1'b1, 8'd1, 64'h1));
		send_request(make_request(FN_LOCK, ~a, 1'b0, KEY_LEN, k));
		send_request(make_request(FN_LOCK, a, 1'b0, 8'd1, 64'hFFFF_FFFF_FFFF_FF00));
		send_request(make_request(FN_LOCK, a, 1'b0, 8'd1, 64'h2));
		send_request(make_request(FN_LOCK, a, 1'b0, 8'd1, 64'hFF));
		send_request(make_request(FN_LOCK, a, 1'b0, KEY_LEN, k));
		send_request(make_request(FN_CONTROL, a, 1'b0, 8'd1, 64'h01));
		send_request(make_request(FN_LOCK, a, 1'b0, 8'd1, 64'h0));
		send_request(make_request(FN_LOCK, a, 1'b0, 8'd1, 64'h1));
		send_request(make_request(FN_LOCK, a, 1'b1, KEY_LEN, k ^ 64'h1));
		send_request(make_request(FN_LOCK, a, 1'b0, KEY_LEN, k));
	endtask

	// Stall the receiver for a long stretch while requests keep coming
	task automatic test_backpressure();
		hold_cycles = HOLD_OFF_CYCLES;
		idle_on = 1'b0;
		run_random(40, 1'b0);
		idle_on = 1'b1;
		wait_drained();
	endtask

	// Enter the keyless lock by one of its two routes, then hammer it
	task automatic test_keyless_lock();
		logic [31:0] a;
		logic [63:0] k;
		a = guard.attr_req;
		if (guard.lock == LK_KEYED)
			send_request(make_request(FN_LOCK, a, 1'b0, KEY_LEN, guard.key));
		if ($urandom_range(0, 1)) begin
			send_request(make_request(FN_LOCK, a, 1'b0, 8'd1, 64'h1));
		end else begin
			k = {$urandom, $urandom};
			send_request(make_request(FN_LOCK, a, 1'b0, KEY_LEN, k));
			send_request(make_request(FN_LOCK, a, 1'b0, KEY_LEN,
				k ^ (64'd1 << $urandom_range(0, KEY_W - 1))));
		end
		run_random(120, 1'b1);
	endtask

	// Receiver: random ready gaps, optional long hold, check each word
	initial begin
		int   gap;
		res_t want;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_tready = 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end
			gap = idle_on ? $urandom_range(0, 3) : 0;
			if (gap != 0) begin
				m_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (pending_results.size() == 0) begin
				$error("m_tdata: no request pending, actual %h", m_tdata);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[1:0] !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, m_tdata[1:0]);
					mismatch_count++;
				end
				if (m_tdata[9:2] !== want.control_value) begin
					$error("control_value: expected %h, actual %h",
						want.control_value, m_tdata[9:2]);
					mismatch_count++;
				end
				if (m_tdata[11:10] !== want.lock_value) begin
					$error("lock_value: expected %0d, actual %0d",
						want.lock_value, m_tdata[11:10]);
					mismatch_count++;
				end
			end
		end
	end

	// Sequence the tests
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		guard.lock = LK_OPEN;
		guard.key = '0;
		guard.ctrl = 8'd0;
		guard.attr_req = ATTR_RESET;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_control_writes();
		test_lock_and_key();

		// Run back to back first, then with gaps on both sides
		idle_on = 1'b0;
		run_random(100, 1'b0);
		idle_on = 1'b1;
		run_random(250, 1'b0);

		write_required_attributes(32'hFFFF_FFFF);
		run_random(250, 1'b0);
		write_required_attributes(32'h0000_0000);
		run_random(250, 1'b0);
		write_required_attributes($urandom);
		run_random(250, 1'b0);
		write_required_attributes(ATTR_RESET);
		run_random(200, 1'b0);

		test_backpressure();
		test_keyless_lock();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
